// ===== sv/dfwz_pkg.sv =====
// -----------------------------------------------------------------------------
// dfwz_pkg
// Shared constants, register indexes, result codes and divider types for the
// forward depth warp with z-buffer.
// -----------------------------------------------------------------------------
package dfwz_pkg;

	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 256;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DEPTH_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SINTR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VINTR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME = 3'd6;

	localparam logic [63:0] ROT0_RST = 64'd16384;
	localparam logic [63:0] ROT1_RST = 64'd1073741824;
	localparam logic [63:0] ROT2_RST = 64'd70368744177664;
	localparam logic [59:0] TRANS_RST = 60'd0;
	localparam logic [63:0] INTR_RST = 64'd576469548664885248;
	localparam logic [23:0] FRAME_RST = 24'd1048832;

	localparam logic [1:0] OC_STORED = 2'd0;
	localparam logic [1:0] OC_OCCLUDED = 2'd1;
	localparam logic [1:0] OC_DROPPED = 2'd2;
	localparam logic [1:0] OC_READOUT = 2'd3;

	localparam int DIV_NUM_W = 60;
	localparam int DIV_DEN_W = 44;

	typedef struct packed {
		logic start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_NUM_W-1:0] quot;
	} div_rsp_t;

	// signed Q2.14 product sum back to integer, truncating toward zero
	function automatic logic signed [43:0] q14_trunc(input logic signed [57:0] acc);
		logic signed [57:0] adj;
		adj = acc + (acc[57] ? 58'sd16383 : 58'sd0);
		return adj[57:14];
	endfunction

endpackage

// ===== sv/dfwz_if.sv =====
// -----------------------------------------------------------------------------
// dfwz interfaces
// Request, result and configuration channels with valid/ready handshake.
// -----------------------------------------------------------------------------
interface dfwz_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [11:0] pixel_row;
	logic [11:0] pixel_col;
	logic [15:0] source_depth;
	modport source (output valid, req_type, pixel_row, pixel_col, source_depth,
		input ready);
	modport sink (input valid, req_type, pixel_row, pixel_col, source_depth,
		output ready);
endinterface

interface dfwz_res_if;
	logic valid;
	logic ready;
	logic [1:0] outcome;
	logic [11:0] target_row;
	logic [11:0] target_col;
	logic [15:0] entry_depth;
	modport source (output valid, outcome, target_row, target_col, entry_depth,
		input ready);
	modport sink (input valid, outcome, target_row, target_col, entry_depth,
		output ready);
endinterface

interface dfwz_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/depth_forward_warp_zbuffer.sv =====
// -----------------------------------------------------------------------------
// depth_forward_warp_zbuffer
// Forward depth warp of source pixels into a nearest-depth z-buffer.
// -----------------------------------------------------------------------------
// Channels: req takes warp and readout items, res returns one result item per
// request, cfg writes the seven setup registers (always ready; write only while
// the block is idle).
// Warp: back-projection and re-projection run four divisions on one shared
// restoring divider (60 iterations each), plus a nine-step multiply-accumulate
// for the rotation.
// A readout item reads and clears its store entry, then passes ST_OUT.
// One item is in work at a time; req is taken again once the result sits in
// the output register, so a stalled res holds only the item after it.
// The store is one synchronous memory with a registered read; read-compare-write
// of an entry finishes before the next item enters, so no forwarding is needed.
// Reset: registers return to identity rotation, zero translation and a
// 256x256 frame; the store is swept to empty, one entry a cycle, through all
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (65536 by default), during which
// req stays low.
// A stalled res holds its item and value until taken.
// -----------------------------------------------------------------------------
module depth_forward_warp_zbuffer import dfwz_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dfwz_req_if.sink   req,
	dfwz_res_if.source res,
	dfwz_cfg_if.sink   cfg
);

	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W = RAW + CAW;
	localparam logic [12:0] ROWS_LIM = 13'(MAX_ROWS);
	localparam logic [12:0] COLS_LIM = 13'(MAX_COLS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDW  = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_DVX  = 4'd3;
	localparam logic [3:0] ST_DVY  = 4'd4;
	localparam logic [3:0] ST_ROT  = 4'd5;
	localparam logic [3:0] ST_ZCK  = 4'd6;
	localparam logic [3:0] ST_MR   = 4'd7;
	localparam logic [3:0] ST_DVR  = 4'd8;
	localparam logic [3:0] ST_MC   = 4'd9;
	localparam logic [3:0] ST_DVC  = 4'd10;
	localparam logic [3:0] ST_RNG  = 4'd11;
	localparam logic [3:0] ST_ZRD  = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;

	// configuration
	logic [63:0] rot0_q, rot1_q, rot2_q, sintr_q, vintr_q;
	logic [59:0] trans_q;
	logic [23:0] frame_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot0_q  <= ROT0_RST;
			rot1_q  <= ROT1_RST;
			rot2_q  <= ROT2_RST;
			trans_q <= TRANS_RST;
			sintr_q <= INTR_RST;
			vintr_q <= INTR_RST;
			frame_q <= FRAME_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROT0:  rot0_q  <= cfg.data;
				REG_ROT1:  rot1_q  <= cfg.data;
				REG_ROT2:  rot2_q  <= cfg.data;
				REG_TRANS: trans_q <= cfg.data[59:0];
				REG_SINTR: sintr_q <= cfg.data;
				REG_VINTR: vintr_q <= cfg.data;
				REG_FRAME: frame_q <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

	logic [15:0] sfx, sfy, sox, soy, vfx, vfy, vox, voy;
	assign sfx = sintr_q[15:0];
	assign sfy = sintr_q[31:16];
	assign sox = sintr_q[47:32];
	assign soy = sintr_q[63:48];
	assign vfx = vintr_q[15:0];
	assign vfy = vintr_q[31:16];
	assign vox = vintr_q[47:32];
	assign voy = vintr_q[63:48];

	logic [12:0] w_lim, h_lim;
	assign w_lim = ({1'b0, frame_q[11:0]} > COLS_LIM) ? COLS_LIM : {1'b0, frame_q[11:0]};
	assign h_lim = ({1'b0, frame_q[23:12]} > ROWS_LIM) ? ROWS_LIM : {1'b0, frame_q[23:12]};

	logic signed [39:0] tx16, ty16, tz16;
	assign tx16 = {{16{trans_q[19]}}, trans_q[19:0], 4'b0};
	assign ty16 = {{16{trans_q[39]}}, trans_q[39:20], 4'b0};
	assign tz16 = {{16{trans_q[59]}}, trans_q[59:40], 4'b0};

	// control and datapath registers
	logic [3:0]  state_q;
	logic [11:0] row_q, col_q;
	logic [15:0] d_q;
	logic signed [34:0] pb_q;
	logic signed [39:0] v0_q, v1_q, v2_q;
	logic signed [57:0] acc_q;
	logic [1:0]  k_q, n_q;
	logic signed [43:0] w0_q, w1_q, w2_q;
	logic signed [44:0] z_q;
	logic [15:0] dz_q;
	logic signed [61:0] num_q, sr_q, sc_q;
	logic [11:0] tr_q, tc_q;
	logic        neg_q;
	logic        start_q;
	logic [DIV_NUM_W-1:0] dnum_q;
	logic [DIV_DEN_W-1:0] dden_q;
	logic [1:0]  roc_q, oc_q;
	logic [11:0] rtr_q, rtc_q, otr_q, otc_q;
	logic [15:0] rdp_q, odp_q;
	logic        ovalid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start = start_q;
	assign div_req.num   = dnum_q;
	assign div_req.den   = dden_q;

	dfwz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// store ports
	logic               rd_en, wr_en, clearing;
	logic [ADDR_W-1:0]  rd_addr, wr_addr;
	logic [DEPTH_W-1:0] rd_data, wr_data;

	dfwz_store #(.ADDR_W(ADDR_W)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	logic accept, in_store;
	assign req.ready = (state_q == ST_IDLE) && !clearing;
	assign accept    = req.valid && req.ready;
	assign in_store  = ({1'b0, req.pixel_row} < ROWS_LIM) && ({1'b0, req.pixel_col} < COLS_LIM);

	// back-projection products
	logic signed [17:0] a_in, b_in;
	logic signed [34:0] ad, bd;
	assign a_in = $signed({2'b0, col_q, 4'b0}) - $signed({2'b0, sox});
	assign b_in = $signed({2'b0, row_q, 4'b0}) - $signed({2'b0, soy});
	assign ad   = a_in * $signed({1'b0, d_q});
	assign bd   = b_in * $signed({1'b0, d_q});

	logic [34:0] ad_abs, pb_abs;
	assign ad_abs = ad[34] ? 35'(-ad) : 35'(ad);
	assign pb_abs = pb_q[34] ? 35'(-pb_q) : 35'(pb_q);

	logic signed [60:0] qs;
	assign qs = neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});

	logic signed [60:0] v1_full, v2_full;
	logic signed [39:0] d16, v0_new;
	assign v1_full = -qs - {{21{ty16[39]}}, ty16};
	assign v2_full = -qs - {{21{tz16[39]}}, tz16};
	assign d16     = {20'b0, d_q, 4'b0};
	assign v0_new  = -d16 - tx16;

	// rotation multiply-accumulate
	logic [63:0] rot_row;
	logic signed [15:0] rm;
	logic signed [39:0] vn;
	logic signed [55:0] prod;
	logic signed [57:0] sum;
	logic signed [43:0] wtr;

	always_comb begin
		unique case (k_q)
			2'd0:    rot_row = rot0_q;
			2'd1:    rot_row = rot1_q;
			default: rot_row = rot2_q;
		endcase
		unique case (n_q)
			2'd0:    vn = v0_q;
			2'd1:    vn = v1_q;
			default: vn = v2_q;
		endcase
	end

	assign rm   = $signed(rot_row[{n_q, 4'b0} +: 16]);
	assign prod = rm * vn;
	assign sum  = ((n_q == 2'd0) ? 58'sd0 : acc_q) + {{2{prod[55]}}, prod};
	assign wtr  = q14_trunc(sum);

	// projected depth and re-projection numerators
	logic signed [44:0] z_new, w1n, w2n;
	logic signed [61:0] mr, mc, num_abs;
	assign z_new   = -{w0_q[43], w0_q};
	assign w1n     = -{w1_q[43], w1_q};
	assign w2n     = -{w2_q[43], w2_q};
	assign mr      = w2n * $signed({1'b0, vfy});
	assign mc      = w1n * $signed({1'b0, vfx});
	assign num_abs = num_q[61] ? -num_q : num_q;

	logic signed [61:0] qs62;
	assign qs62 = {qs[60], qs};

	// target range check
	logic        r_ok, c_ok, rng_ok;
	logic [11:0] tr_val, tc_val;
	assign r_ok   = (sr_q > -62'sd16) && (sr_q[61] ? (h_lim != 13'd0)
		: (sr_q[61:4] < {45'b0, h_lim}));
	assign c_ok   = (sc_q > -62'sd16) && (sc_q[61] ? (w_lim != 13'd0)
		: (sc_q[61:4] < {45'b0, w_lim}));
	assign rng_ok = r_ok && c_ok;
	assign tr_val = sr_q[61] ? 12'd0 : sr_q[15:4];
	assign tc_val = sc_q[61] ? 12'd0 : sc_q[15:4];

	logic take;
	assign take = (rd_data == 16'd0) || (rd_data > dz_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {req.pixel_row[RAW-1:0], req.pixel_col[CAW-1:0]};
		wr_en   = 1'b0;
		wr_addr = {row_q[RAW-1:0], col_q[CAW-1:0]};
		wr_data = '0;
		unique case (state_q)
			ST_IDLE: rd_en = accept && req.req_type && in_store;
			ST_RNG: begin
				rd_en   = rng_ok;
				rd_addr = {tr_val[RAW-1:0], tc_val[CAW-1:0]};
			end
			ST_RDW: wr_en = 1'b1;
			ST_ZRD: begin
				wr_en   = take;
				wr_addr = {tr_q[RAW-1:0], tc_q[CAW-1:0]};
				wr_data = dz_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			start_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_MUL) || (state_q == ST_MR) || (state_q == ST_MC)
				|| ((state_q == ST_DVX) && div_rsp.done);
			if ((state_q == ST_OUT) && (!ovalid_q || res.ready)) begin
				ovalid_q <= 1'b1;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.req_type) begin
							state_q <= in_store ? ST_RDW : ST_OUT;
						end else if (sfx == 16'd0 || sfy == 16'd0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_RDW: state_q <= ST_OUT;
				ST_MUL: state_q <= ST_DVX;
				ST_DVX: begin
					if (div_rsp.done) begin
						state_q <= ST_DVY;
					end
				end
				ST_DVY: begin
					if (div_rsp.done) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (n_q == 2'd2 && k_q == 2'd2) begin
						state_q <= ST_ZCK;
					end
				end
				ST_ZCK: state_q <= (z_new < 45'sd16) ? ST_OUT : ST_MR;
				ST_MR: state_q <= ST_DVR;
				ST_DVR: begin
					if (div_rsp.done) begin
						state_q <= ST_MC;
					end
				end
				ST_MC: state_q <= ST_DVC;
				ST_DVC: begin
					if (div_rsp.done) begin
						state_q <= ST_RNG;
					end
				end
				ST_RNG: state_q <= rng_ok ? ST_ZRD : ST_OUT;
				ST_ZRD: state_q <= ST_OUT;
				ST_OUT: begin
					if (!ovalid_q || res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and result staging
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q <= req.pixel_row;
				col_q <= req.pixel_col;
				d_q   <= req.source_depth;
				if (req.req_type) begin
					roc_q <= OC_READOUT;
					rtr_q <= req.pixel_row;
					rtc_q <= req.pixel_col;
					rdp_q <= '0;
				end else begin
					roc_q <= OC_DROPPED;
					rtr_q <= '0;
					rtc_q <= '0;
					rdp_q <= '0;
				end
			end
			ST_RDW: rdp_q <= rd_data;
			ST_MUL: begin
				dnum_q <= {21'b0, ad_abs, 4'b0};
				dden_q <= {28'b0, sfx};
				neg_q  <= ad[34];
				pb_q   <= bd;
				v0_q   <= v0_new;
			end
			ST_DVX: begin
				if (div_rsp.done) begin
					v1_q   <= v1_full[39:0];
					dnum_q <= {21'b0, pb_abs, 4'b0};
					dden_q <= {28'b0, sfy};
					neg_q  <= pb_q[34];
				end
			end
			ST_DVY: begin
				if (div_rsp.done) begin
					v2_q <= v2_full[39:0];
					k_q  <= 2'd0;
					n_q  <= 2'd0;
				end
			end
			ST_ROT: begin
				acc_q <= sum;
				if (n_q == 2'd2) begin
					unique case (k_q)
						2'd0:    w0_q <= wtr;
						2'd1:    w1_q <= wtr;
						default: w2_q <= wtr;
					endcase
					n_q <= 2'd0;
					k_q <= k_q + 1'b1;
				end else begin
					n_q <= n_q + 1'b1;
				end
			end
			ST_ZCK: begin
				z_q   <= z_new;
				dz_q  <= (z_new >= 45'sd1048576) ? 16'hFFFF : z_new[19:4];
				num_q <= mr;
			end
			ST_MR: begin
				dnum_q <= num_abs[DIV_NUM_W-1:0];
				dden_q <= z_q[DIV_DEN_W-1:0];
				neg_q  <= num_q[61];
			end
			ST_DVR: begin
				if (div_rsp.done) begin
					sr_q  <= qs62 + {46'b0, voy};
					num_q <= mc;
				end
			end
			ST_MC: begin
				dnum_q <= num_abs[DIV_NUM_W-1:0];
				dden_q <= z_q[DIV_DEN_W-1:0];
				neg_q  <= num_q[61];
			end
			ST_DVC: begin
				if (div_rsp.done) begin
					sc_q <= qs62 + {46'b0, vox};
				end
			end
			ST_RNG: begin
				tr_q <= tr_val;
				tc_q <= tc_val;
			end
			ST_ZRD: begin
				roc_q <= take ? OC_STORED : OC_OCCLUDED;
				rtr_q <= tr_q;
				rtc_q <= tc_q;
				rdp_q <= take ? dz_q : rd_data;
			end
			ST_OUT: begin
				if (!ovalid_q || res.ready) begin
					oc_q  <= roc_q;
					otr_q <= rtr_q;
					otc_q <= rtc_q;
					odp_q <= rdp_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid       = ovalid_q;
	assign res.outcome     = oc_q;
	assign res.target_row  = otr_q;
	assign res.target_col  = otc_q;
	assign res.entry_depth = odp_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("item accepted during store clear");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome == OC_DROPPED) |->
		(res.target_row == 12'd0 && res.target_col == 12'd0 && res.entry_depth == 16'd0))
		else $error("dropped result carries nonzero fields");

	a_stored_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome == OC_STORED) |-> res.entry_depth != 16'd0)
		else $error("stored depth is zero");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !div_rsp.busy)
		else $error("divider started while busy");

endmodule

// ===== sv/dfwz_div.sv =====
// -----------------------------------------------------------------------------
// dfwz_div
// Unsigned restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module dfwz_div import dfwz_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] sh_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, sh_q[DIV_NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift in where numerator bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			sh_q  <= req.num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			sh_q  <= {sh_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

// ===== sv/dfwz_store.sv =====
// -----------------------------------------------------------------------------
// dfwz_store
// Depth store: one write and one registered read port, cleared by a sweep
// after reset.
// -----------------------------------------------------------------------------
module dfwz_store import dfwz_pkg::*; #(
	parameter int ADDR_W = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [DEPTH_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [DEPTH_W-1:0] wr_data,
	output logic               clearing
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DEPTH_W-1:0] mem [DEPTH];
	logic [ADDR_W:0]    clr_q;

	assign clearing = ~clr_q[ADDR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[ADDR_W-1:0]] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== verif/tb.sv =====
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for depth_forward_warp_zbuffer. A directed table covers
// reset contents, extremes, occlusion, ties and readout, then random warp and
// readout items run under several camera setups. Each result is checked against
// its table entry or an in-bench fixed-point warp and z-buffer model.
// -----------------------------------------------------------------------------
module tb;
	import dfwz_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 250;

	typedef struct packed {
		logic [1:0] outcome;
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] depth;
	} warp_result_t;

	typedef struct {
		bit rd;
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] depth;
		bit typed;
		warp_result_t want;
	} table_row_t;

	logic clk;
	logic arst_n;

	dfwz_req_if req ();
	dfwz_res_if res ();
	dfwz_cfg_if cfg ();

	depth_forward_warp_zbuffer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.res(res.source),
		.cfg(cfg.sink)
	);

	// shadow of setup registers and the depth store
	logic [63:0] rot_q [3];
	logic [59:0] trans_q;
	logic [63:0] src_intr_q;
	logic [63:0] virt_intr_q;
	logic [23:0] frame_q;
	logic [15:0] zbuf [0:MAX_ROWS_DEF*MAX_COLS_DEF-1];

	warp_result_t pending_q[$];
	int errors;
	int idle_cycles;
	bit quiet;

	initial begin
		clk = 1'b0;
	end
	always #6 clk = ~clk;

	function automatic longint lane_u(input logic [63:0] r, input int k);
		return longint'({48'b0, r[16*k +: 16]});
	endfunction

	function automatic warp_result_t warp_predict(input bit rd, input logic [11:0] row,
			input logic [11:0] col, input logic [15:0] depth);
		warp_result_t o;
		longint d, wd, ht, sfx, sfy, sox, soy, vfx, vfy, vox, voy;
		longint v [3];
		longint w [3];
		longint acc, z, dz, tr, tc;
		int idx;
		o = '0;
		d = longint'({48'b0, depth});
		if (rd) begin
			o.outcome = OC_READOUT;
			o.row = row;
			o.col = col;
			if (row < MAX_ROWS_DEF && col < MAX_COLS_DEF) begin
				idx = int'(row) * MAX_COLS_DEF + int'(col);
				o.depth = zbuf[idx];
				zbuf[idx] = '0;
			end
			return o;
		end
		o.outcome = OC_DROPPED;
		wd = longint'({52'b0, frame_q[11:0]});
		ht = longint'({52'b0, frame_q[23:12]});
		if (wd > MAX_COLS_DEF) wd = longint'(MAX_COLS_DEF);
		if (ht > MAX_ROWS_DEF) ht = longint'(MAX_ROWS_DEF);
		sfx = lane_u(src_intr_q, 0);
		sfy = lane_u(src_intr_q, 1);
		sox = lane_u(src_intr_q, 2);
		soy = lane_u(src_intr_q, 3);
		vfx = lane_u(virt_intr_q, 0);
		vfy = lane_u(virt_intr_q, 1);
		vox = lane_u(virt_intr_q, 2);
		voy = lane_u(virt_intr_q, 3);
		if (sfx == 0 || sfy == 0)
			return o;
		v[0] = -(d * 16);
		v[1] = -(((longint'(col) * 16 - sox) * d * 16) / sfx);
		v[2] = -(((longint'(row) * 16 - soy) * d * 16) / sfy);
		for (int k = 0; k < 3; k++)
			v[k] -= longint'($signed(trans_q[20*k +: 20])) * 16;
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int n = 0; n < 3; n++)
				acc += longint'($signed(rot_q[k][16*n +: 16])) * v[n];
			w[k] = acc / 16384;
		end
		z = -w[0];
		dz = z / 16;
		if (dz < 1)
			return o;
		if (dz > 65535) dz = 65535;
		tr = (((-w[2]) * vfy) / z + voy) / 16;
		tc = (((-w[1]) * vfx) / z + vox) / 16;
		if (tr < 0 || tc < 0 || tr >= ht || tc >= wd)
			return o;
		idx = int'(tr) * MAX_COLS_DEF + int'(tc);
		o.row = tr[11:0];
		o.col = tc[11:0];
		if (zbuf[idx] == 0 || longint'(zbuf[idx]) > dz) begin
			zbuf[idx] = dz[15:0];
			o.outcome = OC_STORED;
			o.depth = dz[15:0];
		end else begin
			o.outcome = OC_OCCLUDED;
			o.depth = zbuf[idx];
		end
		return o;
	endfunction

	task automatic send_item(input bit rd, input logic [11:0] row, input logic [11:0] col,
			input logic [15:0] depth, input bit typed, input warp_result_t want);
		warp_result_t got;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.valid = 1'b1;
		req.req_type = rd;
		req.pixel_row = row;
		req.pixel_col = col;
		req.source_depth = depth;
		do @(posedge clk); while (!req.ready);
		got = warp_predict(rd, row, col, depth);
		pending_q.push_back(typed ? want : got);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
		@(negedge clk);
		req.valid = 1'b0;
		cfg.valid = 1'b1;
		cfg.index = index;
		cfg.data = data;
		do @(posedge clk); while (!cfg.ready);
		case (index)
			REG_ROT0: rot_q[0] = data;
			REG_ROT1: rot_q[1] = data;
			REG_ROT2: rot_q[2] = data;
			REG_TRANS: trans_q = data[59:0];
			REG_SINTR: src_intr_q = data;
			REG_VINTR: virt_intr_q = data;
			REG_FRAME: frame_q = data[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// hold the sender until every result is back, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		req.valid = 1'b0;
		wait (pending_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// span bounds the common row/col range so targets collide and get occluded
	task automatic random_items(input int count, input int span);
		bit rd;
		logic [11:0] row, col;
		logic [15:0] depth;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			rd = (pick < 20);
			if (pick >= 90) begin
				row = 12'($urandom);
				col = 12'($urandom);
			end else begin
				row = 12'($urandom_range(0, span - 1));
				col = 12'($urandom_range(0, span - 1));
			end
			case ($urandom_range(0, 3))
				0: depth = 16'($urandom);
				1: depth = 16'($urandom_range(0, 64));
				default: depth = 16'($urandom_range(100, 4000));
			endcase
			send_item(rd, row, col, depth, 1'b0, '0);
		end
	endtask

	function automatic logic [63:0] rot_row(input int a, input int b, input int c);
		logic [15:0] x, y, q;
		x = a[15:0];
		y = b[15:0];
		q = c[15:0];
		return {16'h0, q, y, x};
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// result side: random stall bursts, check in order
	always @(negedge clk) begin
		if (!arst_n || quiet)
			res.ready <= 1'b1;
		else if ($urandom_range(0, 9) == 0)
			res.ready <= 1'b0;
		else if (!res.ready && $urandom_range(0, 2) == 0)
			res.ready <= 1'b1;
	end

	always @(posedge clk) begin
		warp_result_t want;
		if (res.valid && res.ready) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result outcome=%0d row=%0d col=%0d depth=%0d",
					$time, res.outcome, res.target_row, res.target_col, res.entry_depth);
			end else begin
				want = pending_q.pop_front();
				if (res.outcome !== want.outcome || res.target_row !== want.row ||
						res.target_col !== want.col || res.entry_depth !== want.depth) begin
					errors++;
					$display("%0t: mismatch expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
						$time, want.outcome, want.row, want.col, want.depth,
						res.outcome, res.target_row, res.target_col, res.entry_depth);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		table_row_t steps [$];
		table_row_t t;
		quiet = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.pixel_row = '0;
		req.pixel_col = '0;
		req.source_depth = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		rot_q[0] = ROT0_RST;
		rot_q[1] = ROT1_RST;
		rot_q[2] = ROT2_RST;
		trans_q = TRANS_RST;
		src_intr_q = INTR_RST;
		virt_intr_q = INTR_RST;
		frame_q = FRAME_RST;
		for (int i = 0; i < MAX_ROWS_DEF * MAX_COLS_DEF; i++)
			zbuf[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// rd, row, col, depth, typed, expected
		steps = '{
			'{1'b1, 12'd0, 12'd0, 16'd0, 1'b1, '{OC_READOUT, 12'd0, 12'd0, 16'd0}},
			'{1'b1, 12'd255, 12'd255, 16'hFFFF, 1'b1, '{OC_READOUT, 12'd255, 12'd255, 16'd0}},
			'{1'b1, 12'd300, 12'd5, 16'd7, 1'b1, '{OC_READOUT, 12'd300, 12'd5, 16'd0}},
			'{1'b1, 12'd4095, 12'd4095, 16'd0, 1'b1, '{OC_READOUT, 12'd4095, 12'd4095, 16'd0}},
			'{1'b0, 12'd10, 12'd20, 16'd0, 1'b1, '{OC_DROPPED, 12'd0, 12'd0, 16'd0}},
			'{1'b0, 12'd10, 12'd20, 16'd1000, 1'b1, '{OC_STORED, 12'd10, 12'd20, 16'd1000}},
			'{1'b0, 12'd10, 12'd20, 16'd2000, 1'b1, '{OC_OCCLUDED, 12'd10, 12'd20, 16'd1000}},
			'{1'b0, 12'd10, 12'd20, 16'd500, 1'b1, '{OC_STORED, 12'd10, 12'd20, 16'd500}},
			'{1'b0, 12'd10, 12'd20, 16'd500, 1'b1, '{OC_OCCLUDED, 12'd10, 12'd20, 16'd500}},
			'{1'b1, 12'd10, 12'd20, 16'd0, 1'b1, '{OC_READOUT, 12'd10, 12'd20, 16'd500}},
			'{1'b1, 12'd10, 12'd20, 16'd0, 1'b1, '{OC_READOUT, 12'd10, 12'd20, 16'd0}},
			'{1'b0, 12'd0, 12'd0, 16'hFFFF, 1'b0, '0},
			'{1'b0, 12'd255, 12'd255, 16'hFFFF, 1'b0, '0},
			'{1'b0, 12'd256, 12'd3, 16'd100, 1'b1, '{OC_DROPPED, 12'd0, 12'd0, 16'd0}},
			'{1'b0, 12'd4095, 12'd4095, 16'hFFFF, 1'b1, '{OC_DROPPED, 12'd0, 12'd0, 16'd0}},
			'{1'b0, 12'd0, 12'd0, 16'd1, 1'b0, '0},
			'{1'b1, 12'd0, 12'd0, 16'd0, 1'b0, '0},
			'{1'b1, 12'd255, 12'd255, 16'd0, 1'b0, '0}
		};
		foreach (steps[i]) begin
			t = steps[i];
			send_item(t.rd, t.row, t.col, t.depth, t.typed, t.want);
		end
		random_items(330, 24);
		drain();

		// small rotation, offset camera, smaller frame
		write_reg(REG_ROT0, rot_row(16384 + jitter(300), jitter(600), jitter(600)));
		write_reg(REG_ROT1, rot_row(jitter(600), 16384 + jitter(300), jitter(600)));
		write_reg(REG_ROT2, rot_row(jitter(600), jitter(600), 16384 + jitter(300)));
		write_reg(REG_TRANS, {4'h0, 20'(jitter(40)), 20'(jitter(40)), 20'(jitter(40))});
		write_reg(REG_SINTR, {16'(1024 + jitter(200)), 16'(1024 + jitter(200)),
			16'($urandom_range(800, 4000)), 16'($urandom_range(800, 4000))});
		write_reg(REG_VINTR, {16'(1024 + jitter(200)), 16'(1024 + jitter(200)),
			16'($urandom_range(800, 4000)), 16'($urandom_range(800, 4000))});
		write_reg(REG_FRAME, 64'({12'd96, 12'd128}));
		random_items(330, 40);
		drain();

		// zero source focal length drops every warp
		write_reg(REG_SINTR, 64'h0800_0800_0800_0000);
		random_items(40, 24);
		drain();
		write_reg(REG_SINTR, 64'h0800_0800_0000_0800);
		random_items(20, 24);
		drain();

		// extremes of every register, frame zero then oversized
		write_reg(REG_ROT0, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_ROT1, rot_row(32767, 32767, 32767));
		write_reg(REG_ROT2, 64'h0000_8000_8000_8000);
		write_reg(REG_TRANS, 64'h0FFF_FFFF_FFFF_FFFF);
		write_reg(REG_SINTR, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_VINTR, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_FRAME, 64'h0);
		random_items(40, 24);
		drain();
		write_reg(REG_FRAME, 64'h00FF_FFFF);
		write_reg(REG_TRANS, 64'({20'h80000, 20'h7FFFF, 20'h00000}));
		write_reg(REG_ROT0, rot_row(16384, 0, 0));
		random_items(60, 256);
		drain();
		write_reg(REG_VINTR, 64'h0000_0000_0001_0001);
		write_reg(REG_TRANS, 64'd0);
		random_items(40, 64);
		drain();

		// back to the reset camera over the full store, no idling at the end
		write_reg(REG_ROT0, ROT0_RST);
		write_reg(REG_ROT1, ROT1_RST);
		write_reg(REG_ROT2, ROT2_RST);
		write_reg(REG_SINTR, INTR_RST);
		write_reg(REG_VINTR, INTR_RST);
		random_items(250, 32);
		quiet = 1'b1;
		random_items(120, 32);
		drain();

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
